// ----- sv/tlcld_pkg.sv -----
// Shared types and constants for the two-limb CRT decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package tlcld_pkg;

  localparam int WORD_W      = 32;
  localparam int WIDE_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECOND_MODULUS       = 3'd0,
    CFG_INV_SECOND_MOD_FIRST = 3'd1,
    CFG_INV_FIRST_MOD_SECOND = 3'd2,
    CFG_SCALE_FACTOR         = 3'd3,
    CFG_PLAIN_MODULUS        = 3'd4
  } cfg_idx_t;

  // Configuration as seen by the datapath; zero kappa and zero scale are already mapped to one.
  typedef struct packed {
    logic [WORD_W-1:0] kap;
    logic [WORD_W-1:0] inv_sm_f;
    logic [WORD_W-1:0] inv_f_sm;
    logic [WIDE_W-1:0] del;
    logic [WORD_W-1:0] p;
  } cfg_t;

  // Item handed from front to back. d1 uses only its low LIMB_BITS bits.
  typedef struct packed {
    logic [WORD_W-1:0] d1;
    logic [WORD_W-1:0] c2;
    logic [WORD_W-1:0] m2;
  } fe_item_t;

endpackage
`default_nettype wire

// ----- sv/tlcld_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on tlcld_pkg; the divisor must stay stable while items are inside.
`default_nettype none
module tlcld_div_pipe
  import tlcld_pkg::*;
#(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 64,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       quo,
  output logic [DEN_W-1:0]       rem,
  output logic [SIDE_W-1:0]      side_out
);

  logic              stg_valid [NUM_W];
  logic [NUM_W-1:0]  stg_work  [NUM_W];
  logic [DEN_W-1:0]  stg_rem   [NUM_W];
  logic [SIDE_W-1:0] stg_side  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              v_in;
    logic [NUM_W-1:0]  w_in;
    logic [DEN_W-1:0]  r_in;
    logic [SIDE_W-1:0] s_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign w_in = num;
      assign r_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = stg_valid[i-1];
      assign w_in = stg_work[i-1];
      assign r_in = stg_rem[i-1];
      assign s_in = stg_side[i-1];
    end

    assign trial = {r_in, w_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[i] <= 1'b0;
      end else if (en) begin
        stg_valid[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_work[i] <= {w_in[NUM_W-2:0], ge};
        stg_rem[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        stg_side[i] <= s_in;
      end
    end
  end

  assign out_valid = stg_valid[NUM_W-1];
  assign quo       = stg_work[NUM_W-1];
  assign rem       = stg_rem[NUM_W-1];
  assign side_out  = stg_side[NUM_W-1];

endmodule
`default_nettype wire

// ----- sv/tlcld_front.sv -----
// Front stage: accepts input items, forms the first-limb difference.
// Depends on tlcld_pkg; feeds tlcld_queue.
`default_nettype none
module tlcld_front
  import tlcld_pkg::*;
#(
  parameter int LIMB_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] cipher_first_limb,
  input  wire logic [WORD_W-1:0] cipher_second_limb,
  input  wire logic [WORD_W-1:0] mask_first_limb,
  input  wire logic [WORD_W-1:0] mask_second_limb,
  input  wire logic              q_full,
  output logic                   push,
  output fe_item_t               push_item
);

  logic            held;
  fe_item_t        item;
  logic            load;
  logic [LIMB_BITS-1:0] d1;

  assign in_stall = held && q_full;
  assign push     = held && !q_full;
  assign load     = in_valid && !in_stall;
  assign d1       = cipher_first_limb[LIMB_BITS-1:0] - mask_first_limb[LIMB_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.d1 <= WORD_W'(d1);
      item.c2 <= cipher_second_limb;
      item.m2 <= mask_second_limb;
    end
  end

  assign push_item = item;

endmodule
`default_nettype wire

// ----- sv/tlcld_queue.sv -----
// Short FIFO between the front and back stages.
// Depends on tlcld_pkg for the item type and depth.
`default_nettype none
module tlcld_queue
  import tlcld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire fe_item_t push_item,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output fe_item_t      head_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fe_item_t         entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tlcld_back.sv -----
// Back pipeline: second-limb reduction, CRT recombination and rounding.
// Depends on tlcld_pkg and tlcld_div_pipe; takes items from tlcld_queue.
`default_nettype none
module tlcld_back
  import tlcld_pkg::*;
#(
  parameter int LIMB_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  input  wire fe_item_t          in_item,
  output logic                   in_take,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      plain_value
);

  logic en;
  assign en      = !out_valid || !out_stall;
  assign in_take = en;

  // Reduce both second limbs modulo kappa.
  logic                 vc;
  logic [WORD_W-1:0]    rc;
  logic [WORD_W-1:0]    rm;
  logic [LIMB_BITS-1:0] d1c;
  logic                 vm_unused;
  logic [WORD_W-1:0]    qc_unused;
  logic [WORD_W-1:0]    qm_unused;
  logic                 sm_unused;

  tlcld_div_pipe #(.NUM_W(WORD_W), .DEN_W(WORD_W), .SIDE_W(LIMB_BITS)) u_div_c (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .num      (in_item.c2),
    .den      (cfg.kap),
    .side_in  (in_item.d1[LIMB_BITS-1:0]),
    .out_valid(vc),
    .quo      (qc_unused),
    .rem      (rc),
    .side_out (d1c)
  );

  tlcld_div_pipe #(.NUM_W(WORD_W), .DEN_W(WORD_W), .SIDE_W(1)) u_div_m (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .num      (in_item.m2),
    .den      (cfg.kap),
    .side_in  (1'b0),
    .out_valid(vm_unused),
    .quo      (qm_unused),
    .rem      (rm),
    .side_out (sm_unused)
  );

  // Modular difference of the second limbs.
  logic                 v1;
  logic [WORD_W-1:0]    d2_1;
  logic [LIMB_BITS-1:0] d1_1;
  logic [WORD_W:0]      wrap_sum;

  assign wrap_sum = {1'b0, rc} + {1'b0, cfg.kap} - {1'b0, rm};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_1 <= (rc >= rm) ? (rc - rm) : wrap_sum[WORD_W-1:0];
      d1_1 <= d1c;
    end
  end

  // Both CRT products.
  logic                     v2;
  logic [WIDE_W-1:0]        prod2;
  logic [LIMB_BITS-1:0]     t1_2;
  logic [2*LIMB_BITS-1:0]   t1_full;

  assign t1_full = d1_1 * cfg.inv_sm_f[LIMB_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= d2_1 * cfg.inv_f_sm;
      t1_2  <= t1_full[LIMB_BITS-1:0];
    end
  end

  // t2 = product modulo kappa.
  logic                 vt;
  logic [WIDE_W-1:0]    qt_unused;
  logic [WORD_W-1:0]    t2t;
  logic [LIMB_BITS-1:0] t1t;

  tlcld_div_pipe #(.NUM_W(WIDE_W), .DEN_W(WORD_W), .SIDE_W(LIMB_BITS)) u_div_t (
    .clk, .rst, .en,
    .in_valid (v2),
    .num      (prod2),
    .den      (cfg.kap),
    .side_in  (t1_2),
    .out_valid(vt),
    .quo      (qt_unused),
    .rem      (t2t),
    .side_out (t1t)
  );

  // a = t1 * kappa.
  logic                      v3;
  logic [WIDE_W-1:0]         a3;
  logic [WORD_W-1:0]         t2_3;
  logic [LIMB_BITS+WORD_W-1:0] a_prod;

  assign a_prod = t1t * cfg.kap;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3   <= WIDE_W'(a_prod);
      t2_3 <= t2t;
    end
  end

  // Recombine into [0, kappa * 2^LIMB_BITS) without overflow.
  logic              v4;
  logic [WIDE_W-1:0] x4;
  logic [WIDE_W-1:0] big;
  logic [WIDE_W-1:0] b_term;
  logic [WIDE_W-1:0] room;

  assign big    = WIDE_W'({cfg.kap, {LIMB_BITS{1'b0}}});
  assign b_term = WIDE_W'({t2_3, {LIMB_BITS{1'b0}}});
  assign room   = big - b_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4 <= (a3 >= room) ? (a3 - room) : (a3 + b_term);
    end
  end

  // Divide by the scale.
  logic              vx;
  logic [WIDE_W-1:0] qx;
  logic [WIDE_W-1:0] rx;
  logic              sx_unused;

  tlcld_div_pipe #(.NUM_W(WIDE_W), .DEN_W(WIDE_W), .SIDE_W(1)) u_div_x (
    .clk, .rst, .en,
    .in_valid (v4),
    .num      (x4),
    .den      (cfg.del),
    .side_in  (1'b0),
    .out_valid(vx),
    .quo      (qx),
    .rem      (rx),
    .side_out (sx_unused)
  );

  // Round, fold p to zero, saturate.
  logic [WIDE_W-1:0] q_rnd;
  logic [WORD_W-1:0] result;

  assign q_rnd = qx + WIDE_W'(rx >= (cfg.del - (cfg.del >> 1)));

  always_comb begin
    if (q_rnd == WIDE_W'(cfg.p)) begin
      result = '0;
    end else if (q_rnd[WIDE_W-1:WORD_W] != '0) begin
      result = '1;
    end else begin
      result = q_rnd[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plain_value <= result;
    end
  end

endmodule
`default_nettype wire

// ----- sv/two_limb_crt_lwe_decode.sv -----
// Two-limb CRT LWE decoder, top level with the configuration registers.
// Depends on tlcld_pkg, tlcld_front, tlcld_queue and tlcld_back.
//
// Usage: each input item carries the two residue limbs of one ciphertext
// element and of the matching row of H*sk. The block subtracts limb-wise,
// joins the difference by CRT into one value modulo kappa * 2^LIMB_BITS,
// rounds it by the scale and returns one plaintext element per item.
// Both channels use valid and stall: an item moves on a clock edge where
// valid is high and stall is low. The configuration channel is always
// ready; registers are to be written only while the block holds no item,
// which the block itself does not enforce. Throughput is one item per cycle
// while the output is not stalled. After its item is accepted, a result passes
// through the front register, the queue, the three bit-serial division pipelines
// in the back part (32 stages for the limb reduction, 64 for the product reduction,
// 64 for the scaling) and five single registers. A front register and a two-item
// queue let the input keep flowing while the output is stalled; a stall while a
// result is valid freezes the back pipeline and, once the queue fills, raises in_stall. The output register holds its
// item steady under stall. Synchronous reset empties the pipeline and loads
// the register defaults; no clearing pass is needed.
`default_nettype none
module two_limb_crt_lwe_decode
  import tlcld_pkg::*;
#(
  parameter int LIMB_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [WORD_W-1:0]    cipher_first_limb,
  input  wire logic [WORD_W-1:0]    cipher_second_limb,
  input  wire logic [WORD_W-1:0]    mask_first_limb,
  input  wire logic [WORD_W-1:0]    mask_second_limb,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WORD_W-1:0]         plain_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDE_W-1:0]    cfg_data
);

  // Register file. Zero kappa and zero scale are stored as one, which is
  // how the datapath must treat them.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kap      <= WORD_W'(3);
      cfg.inv_sm_f <= WORD_W'(1);
      cfg.inv_f_sm <= WORD_W'(1);
      cfg.del      <= WIDE_W'(1);
      cfg.p        <= WORD_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SECOND_MODULUS: begin
          cfg.kap <= (cfg_data[WORD_W-1:0] == '0) ? WORD_W'(1) : cfg_data[WORD_W-1:0];
        end
        CFG_INV_SECOND_MOD_FIRST: cfg.inv_sm_f <= cfg_data[WORD_W-1:0];
        CFG_INV_FIRST_MOD_SECOND: cfg.inv_f_sm <= cfg_data[WORD_W-1:0];
        CFG_SCALE_FACTOR: begin
          cfg.del <= (cfg_data == '0) ? WIDE_W'(1) : cfg_data;
        end
        CFG_PLAIN_MODULUS: cfg.p <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  logic     q_full;
  logic     push;
  fe_item_t push_item;
  logic     q_not_empty;
  fe_item_t head_item;
  logic     take;

  tlcld_front #(.LIMB_BITS(LIMB_BITS)) u_front (
    .clk, .rst,
    .in_valid,
    .in_stall,
    .cipher_first_limb,
    .cipher_second_limb,
    .mask_first_limb,
    .mask_second_limb,
    .q_full,
    .push,
    .push_item
  );

  tlcld_queue u_queue (
    .clk, .rst,
    .push,
    .push_item,
    .full     (q_full),
    .pop      (take),
    .not_empty(q_not_empty),
    .head_item
  );

  tlcld_back #(.LIMB_BITS(LIMB_BITS)) u_back (
    .clk, .rst,
    .cfg,
    .in_valid (q_not_empty),
    .in_item  (head_item),
    .in_take  (take),
    .out_valid,
    .out_stall,
    .plain_value
  );

endmodule
`default_nettype wire

// ----- tb/two_limb_crt_lwe_decode_test.sv -----
// Self-checking testbench for the two-limb CRT LWE decoder.
// Depends on tlcld_pkg and two_limb_crt_lwe_decode; needs no other file.
// Items go in with random gaps, and results come out under random stall.
// Each result is checked against a predictor that is kept in step with
// every configuration write.
`default_nettype none
module two_limb_crt_lwe_decode_test;
  import tlcld_pkg::*;

  localparam int LIMB = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [63:0] LIMB_MASK = (64'd1 << LIMB) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [WORD_W-1:0] cipher_first_limb = '0;
  logic [WORD_W-1:0] cipher_second_limb = '0;
  logic [WORD_W-1:0] mask_first_limb = '0;
  logic [WORD_W-1:0] mask_second_limb = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WORD_W-1:0] plain_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDE_W-1:0] cfg_data = '0;

  two_limb_crt_lwe_decode #(.LIMB_BITS(LIMB)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cipher_first_limb(cipher_first_limb), .cipher_second_limb(cipher_second_limb),
    .mask_first_limb(mask_first_limb), .mask_second_limb(mask_second_limb),
    .out_valid(out_valid), .out_stall(out_stall), .plain_value(plain_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the register file, as written (zero is mapped at use).
  logic [63:0] kappa_reg, inv_kappa_reg, inv_pow_reg, scale_reg, plain_mod_reg;

  logic [31:0] expected_plain[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int idle_count = 0;

  // Idling knobs: zero maximum means the side never idles.
  int gap_max = 0;
  int stall_max = 0;
  int stall_left = 0;
  int hold_cycles = 0;

  // Decodes one item under the current shadow registers.
  function automatic logic [31:0] decode_plain(logic [31:0] c1, logic [31:0] c2,
                                                logic [31:0] m1, logic [31:0] m2);
    logic [63:0] kap, del, d1, r_c, r_m, d2, t1, t2, a, b, room, x, quo, rem, half;
    kap = (kappa_reg == 0) ? 64'd1 : kappa_reg;
    del = (scale_reg == 0) ? 64'd1 : scale_reg;
    d1 = ({32'd0, c1} - {32'd0, m1}) & LIMB_MASK;
    r_c = {32'd0, c2} % kap;
    r_m = {32'd0, m2} % kap;
    d2 = (r_c + kap - r_m) % kap;
    // CRT join: x = t1*kappa + t2*2^LIMB, folded into [0, kappa*2^LIMB).
    t1 = (d1 * (inv_kappa_reg & LIMB_MASK)) & LIMB_MASK;
    t2 = (d2 * inv_pow_reg) % kap;
    a = t1 * kap;
    b = t2 << LIMB;
    room = (kap << LIMB) - b;
    x = (a >= room) ? a - room : a + b;
    half = del >> 1;
    quo = x / del;
    rem = x % del;
    if (rem >= del - half) quo = quo + 64'd1;
    if (quo == plain_mod_reg) quo = 64'd0;
    if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
    return quo[31:0];
  endfunction

  // Receiver: stall drawn per result, plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        stall_left <= (stall_max == 0) ? 0 : $urandom_range(stall_max, 0);
        if (expected_plain.size() == 0) begin
          $error("plain_value: unexpected item, actual %0d", plain_value);
          errors++;
        end else begin
          logic [31:0] want;
          want = expected_plain.pop_front();
          if (plain_value !== want) begin
            $error("plain_value: expected %0d actual %0d", want, plain_value);
            errors++;
          end
        end
      end
    end
  end

  // Sends one item; valid stays high across back-to-back items.
  task automatic send_item(logic [31:0] c1, logic [31:0] c2, logic [31:0] m1,
                           logic [31:0] m2);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cipher_first_limb <= c1;
    cipher_second_limb <= c2;
    mask_first_limb <= m1;
    mask_second_limb <= m2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_plain.push_back(decode_plain(c1, c2, m1, m2));
    items_sent++;
  endtask

  task automatic send_random_item();
    logic [31:0] k;
    k = (kappa_reg == 0) ? 32'd1 : kappa_reg[31:0];
    // Mostly well-formed second limbs below kappa, sometimes any 32-bit value.
    if ($urandom_range(3, 0) != 0)
      send_item($urandom, $urandom % k, $urandom, $urandom % k);
    else
      send_item($urandom, $urandom, $urandom, $urandom);
  endtask

  // Waits until every result is back and the pipeline has drained.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_plain.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SECOND_MODULUS:       kappa_reg = {32'd0, value[31:0]};
      CFG_INV_SECOND_MOD_FIRST: inv_kappa_reg = {32'd0, value[31:0]};
      CFG_INV_FIRST_MOD_SECOND: inv_pow_reg = {32'd0, value[31:0]};
      CFG_SCALE_FACTOR:         scale_reg = value;
      CFG_PLAIN_MODULUS:        plain_mod_reg = {32'd0, value[31:0]};
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [63:0] k, logic [63:0] ik, logic [63:0] ip,
                           logic [63:0] s, logic [63:0] p);
    write_reg(CFG_SECOND_MODULUS, k);
    write_reg(CFG_INV_SECOND_MOD_FIRST, ik);
    write_reg(CFG_INV_FIRST_MOD_SECOND, ip);
    write_reg(CFG_SCALE_FACTOR, s);
    write_reg(CFG_PLAIN_MODULUS, p);
  endtask

  // Reset defaults: limb extremes, mask above cipher, second limbs above kappa.
  task automatic test_reset_defaults();
    gap_max = 0;
    stall_max = 0;
    send_item(32'd0, 32'd0, 32'd0, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd0, 32'd2, 32'hFFFF_FFFF, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd7, 32'd0, 32'd100);
    send_item(32'h8000_0000, 32'd1, 32'h0000_0001, 32'd2);
    send_item(32'd3, 32'd3, 32'd1, 32'd5);
    wait_drained();
  endtask

  // Zero kappa and zero scale, the quotient hitting p, and saturation.
  task automatic test_special_cases();
    // Kappa zero acts as one, so x equals d1 and scale one keeps it whole.
    write_all(64'd0, 64'd1, 64'd1, 64'd0, 64'd5);
    send_item(32'd5, 32'd9, 32'd0, 32'd4);
    send_item(32'd10, 32'd0, 32'd5, 32'd0);
    send_item(32'd6, 32'd0, 32'd0, 32'd0);
    send_item(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    wait_drained();
    // Largest kappa with scale one: the quotient overflows 32 bits.
    write_all(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'd1, 64'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0, 32'd0);
    send_item(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0);
    send_item(32'd1, 32'd0, 32'd0, 32'd0);
    send_item(32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    wait_drained();
    // Largest scale: everything rounds to zero or one; odd and even rounding.
    write_all(64'd2, 64'd1, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2);
    send_item(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
    send_item(32'd0, 32'd0, 32'd0, 32'd0);
    wait_drained();
    write_all(64'd3, 64'd1, 64'd1, 64'd4, 64'd2);
    send_item(32'd2, 32'd0, 32'd0, 32'd0);
    send_item(32'd6, 32'd0, 32'd0, 32'd0);
    send_item(32'd5, 32'd0, 32'd0, 32'd0);
    wait_drained();
  endtask

  // Random register settings, each followed by a burst of random items.
  task automatic test_random_settings(int phases, int per_phase);
    logic [63:0] k, ik, s, p;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(3, 0))
        0: k = {32'd0, $urandom_range(1000, 0)};
        1: k = 64'hFFFF_FFFF;
        default: k = {32'd0, $urandom | 32'd1};
      endcase
      // Usually the true inverse of kappa modulo 2^32, found by Newton steps.
      ik = k | 64'd1;
      for (int n = 0; n < 5; n++) ik = (ik * (64'd2 - k * ik)) & LIMB_MASK;
      if ($urandom_range(3, 0) == 0) ik = {32'd0, $urandom};
      p = {32'd0, (ph % 3 == 0) ? $urandom_range(16, 2) : $urandom};
      case ($urandom_range(4, 0))
        0: s = 64'd0;
        1: s = {$urandom, $urandom};
        2: s = {32'd0, $urandom_range(64, 1)};
        default: s = (((k == 0) ? 64'd1 : k) << 32) / ((p == 0) ? 64'd1 : p) + 64'd1;
      endcase
      write_all(k, ik, {32'd0, $urandom}, s, p);
      gap_max = (ph % 4 == 1) ? 0 : 17;
      stall_max = (ph % 4 == 2) ? 0 : 17;
      repeat (per_phase) send_random_item();
      wait_drained();
    end
  endtask

  // The receiver holds off for a long time while items keep coming, long
  // enough for the pipeline, the queue and the front register to fill.
  task automatic test_output_backpressure();
    gap_max = 0;
    stall_max = 0;
    hold_cycles = 400;
    repeat (180) send_random_item();
    gap_max = 17;
    stall_max = 17;
    repeat (20) send_random_item();
    wait_drained();
  endtask

  initial begin
    kappa_reg = 64'd3;
    inv_kappa_reg = 64'd1;
    inv_pow_reg = 64'd1;
    scale_reg = 64'd1;
    plain_mod_reg = 64'd2;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_special_cases();
    test_output_backpressure();
    test_random_settings(10, 91);
    $display("Covered %0d items, %0d results checked, %0d register writes.",
             items_sent, results_seen, cfg_writes);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- two_limb_crt_lwe_decode.f -----
sv/tlcld_pkg.sv
sv/tlcld_div_pipe.sv
sv/tlcld_front.sv
sv/tlcld_queue.sv
sv/tlcld_back.sv
sv/two_limb_crt_lwe_decode.sv
tb/two_limb_crt_lwe_decode_test.sv
